### hdl/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int DEPTH   = 16;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MAX_RES = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_DEL   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_REARM = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NF    = 2'd3;

    localparam logic [1:0] MODE_FREE    = 2'd0;
    localparam logic [1:0] MODE_QUEUED  = 2'd1;
    localparam logic [1:0] MODE_WAITING = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] delay_ms;
        logic [31:0] target_id;
        logic        keep;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] event_id;
        logic        expired;
        logic        last;
        logic [15:0] wait_ms;
        logic        queue_empty;
    } t_rsp;

    // slot store write command
    typedef struct packed {
        logic              wr_idp;
        logic              wr_due;
        logic              wr_mode;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       id;
        logic [31:0]       due;
        logic [15:0]       period;
        logic [1:0]        mode;
    } t_slot_wr;

    // order list command
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [CNT_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
    } t_ord_cmd;

endpackage

### hdl/teq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_if
// Request and response channels of the timed event queue.
// ----------------------------------------------------------------------------
interface teq_req_if import teq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface teq_rsp_if import teq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/timed_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Sorted timer event queue: add, delete, millisecond tick and rearm.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready rises again once its last response
// sits in the output register. A sequencer walks the stored events through a
// single read port and one offset subtractor, one entry per cycle: an add
// walks the queued events ahead of it, a delete walks the queue until the id
// matches, a rearm scans every slot and, when it requeues, walks the queued
// events ahead of it, and a tick walks the due events from the head, up to
// MAX_RES of them, and then sends one expired response for each.
// Responses leave through a one-entry output register, so a stalled sink
// holds the sequencer only when a second response is ready to go.
// ----------------------------------------------------------------------------
module timed_event_queue_core import teq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    teq_req_if.sink    i_req,
    teq_rsp_if.source  o_rsp
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_DEL   = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_REARM = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_POP   = 3'd7;

    logic [2:0]        r_state,  n_state;
    logic [CNT_W-1:0]  r_idx,    n_idx;
    logic [CNT_W-1:0]  r_ndue,   n_ndue;
    logic [1:0]        r_op,     n_op;
    logic [31:0]       r_tid,    n_tid;
    logic              r_keep,   n_keep;
    logic [SLOT_W-1:0] r_slot,   n_slot;
    logic [15:0]       r_newoff, n_newoff;
    logic [1:0]        r_status, n_status;
    logic [31:0]       r_res_id, n_res_id;
    logic [15:0]       r_wait,   n_wait;
    logic              r_empty,  n_empty;
    logic [31:0]       r_now,    n_now;
    logic [31:0]       r_next_id, n_next_id;
    logic              r_out_valid;
    t_rsp              r_out,    n_out;
    logic              out_load;
    logic              out_free;

    t_slot_wr          slot_wr;
    t_ord_cmd          ord_cmd;
    logic [SLOT_W-1:0] rd_slot;
    logic [CNT_W-1:0]  ord_rd_pos;
    logic [SLOT_W-1:0] ord_rd_slot;
    logic [CNT_W-1:0]  count;
    logic [31:0]       rd_id;
    logic [31:0]       rd_due;
    logic [15:0]       rd_period;
    logic [1:0]        rd_mode;
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic [31:0]       off;
    logic              in_fire;

    teq_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (slot_wr),
        .i_rd_slot   (rd_slot),
        .o_rd_id     (rd_id),
        .o_rd_due    (rd_due),
        .o_rd_period (rd_period),
        .o_rd_mode   (rd_mode),
        .o_free_any  (free_any),
        .o_free_slot (free_slot)
    );

    teq_order u_order (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ord_cmd),
        .i_rd_pos  (ord_rd_pos),
        .o_rd_slot (ord_rd_slot),
        .o_count   (count)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign ord_rd_pos = (r_state == S_POP) ? '0 : r_idx;
    assign rd_slot    = (r_state == S_REARM) ? r_idx[SLOT_W-1:0] : ord_rd_slot;
    assign off        = rd_due - r_now;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_ndue    = r_ndue;
        n_op      = r_op;
        n_tid     = r_tid;
        n_keep    = r_keep;
        n_slot    = r_slot;
        n_newoff  = r_newoff;
        n_status  = r_status;
        n_res_id  = r_res_id;
        n_wait    = r_wait;
        n_empty   = r_empty;
        n_now     = r_now;
        n_next_id = r_next_id;
        n_out     = r_out;
        out_load  = 1'b0;
        slot_wr   = '0;
        ord_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op     = i_req.data.operation;
                    n_tid    = i_req.data.target_id;
                    n_keep   = i_req.data.keep;
                    n_idx    = '0;
                    n_ndue   = '0;
                    n_status = ST_OK;
                    n_res_id = '0;
                    unique case (i_req.data.operation)
                        OP_ADD: begin
                            if (i_req.data.delay_ms == 16'd0) begin
                                n_status = ST_ZERO;
                                n_state  = S_WAIT;
                            end else if (!free_any) begin
                                n_status = ST_FULL;
                                n_state  = S_WAIT;
                            end else begin
                                slot_wr.wr_idp = 1'b1;
                                slot_wr.wr_due = 1'b1;
                                slot_wr.slot   = free_slot;
                                slot_wr.id     = r_next_id;
                                slot_wr.due    = r_now + {16'd0, i_req.data.delay_ms};
                                slot_wr.period = i_req.data.delay_ms;
                                n_slot         = free_slot;
                                n_newoff       = i_req.data.delay_ms;
                                n_res_id       = r_next_id;
                                n_next_id      = r_next_id + 32'd1;
                                n_state        = S_FIND;
                            end
                        end
                        OP_DEL:  n_state = S_DEL;
                        OP_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_state = S_TICK;
                        end
                        OP_REARM: n_state = S_REARM;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                // first queued entry strictly later than the new one
                if (r_idx == count || off > {16'd0, r_newoff}) begin
                    ord_cmd.ins     = 1'b1;
                    ord_cmd.pos     = r_idx;
                    ord_cmd.slot    = r_slot;
                    slot_wr.wr_mode = 1'b1;
                    slot_wr.slot    = r_slot;
                    slot_wr.mode    = MODE_QUEUED;
                    n_idx           = '0;
                    n_state         = S_WAIT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DEL: begin
                if (r_idx == count) begin
                    n_status = ST_NF;
                    n_idx    = '0;
                    n_state  = S_WAIT;
                end else if (rd_id == r_tid) begin
                    ord_cmd.rem     = 1'b1;
                    ord_cmd.pos     = r_idx;
                    slot_wr.wr_mode = 1'b1;
                    slot_wr.slot    = ord_rd_slot;
                    slot_wr.mode    = MODE_FREE;
                    n_idx           = '0;
                    n_state         = S_WAIT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_TICK: begin
                // count due entries from the head; wait is taken after them
                if (r_idx == count || r_idx == CNT_W'(MAX_RES) ||
                    (off != 32'd0 && !off[31])) begin
                    n_ndue  = r_idx;
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_REARM: begin
                if (rd_mode == MODE_WAITING && rd_id == r_tid) begin
                    if (r_keep) begin
                        slot_wr.wr_due = 1'b1;
                        slot_wr.slot   = r_idx[SLOT_W-1:0];
                        slot_wr.due    = r_now + {16'd0, rd_period};
                        n_slot         = r_idx[SLOT_W-1:0];
                        n_newoff       = rd_period;
                        n_idx          = '0;
                        n_state        = S_FIND;
                    end else begin
                        slot_wr.wr_mode = 1'b1;
                        slot_wr.slot    = r_idx[SLOT_W-1:0];
                        slot_wr.mode    = MODE_FREE;
                        n_idx           = '0;
                        n_state         = S_WAIT;
                    end
                end else if (r_idx == CNT_W'(DEPTH - 1)) begin
                    n_status = ST_NF;
                    n_idx    = '0;
                    n_state  = S_WAIT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_WAIT: begin
                if (r_idx == count) begin
                    n_empty = 1'b1;
                    n_wait  = '0;
                end else begin
                    n_empty = 1'b0;
                    if (off[31]) begin
                        n_wait = '0;
                    end else if (|off[30:16]) begin
                        n_wait = 16'hFFFF;
                    end else begin
                        n_wait = off[15:0];
                    end
                end
                n_state = (r_op == OP_TICK && r_ndue != '0) ? S_POP : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.status      = r_status;
                    n_out.event_id    = r_res_id;
                    n_out.expired     = 1'b0;
                    n_out.last        = 1'b1;
                    n_out.wait_ms     = r_wait;
                    n_out.queue_empty = r_empty;
                    n_state           = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.event_id    = rd_id;
                    n_out.expired     = 1'b1;
                    n_out.last        = (r_ndue == CNT_W'(1));
                    n_out.wait_ms     = r_wait;
                    n_out.queue_empty = r_empty;
                    ord_cmd.rem       = 1'b1;
                    ord_cmd.pos       = '0;
                    slot_wr.wr_mode   = 1'b1;
                    slot_wr.slot      = ord_rd_slot;
                    slot_wr.mode      = MODE_WAITING;
                    n_ndue            = r_ndue - CNT_W'(1);
                    if (r_ndue == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_next_id   <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_next_id <= n_next_id;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ndue   <= n_ndue;
        r_op     <= n_op;
        r_tid    <= n_tid;
        r_keep   <= n_keep;
        r_slot   <= n_slot;
        r_newoff <= n_newoff;
        r_status <= n_status;
        r_res_id <= n_res_id;
        r_wait   <= n_wait;
        r_empty  <= n_empty;
        r_out    <= n_out;
    end

endmodule

### hdl/teq_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_slots
// Per-slot event store with one write port, one read port and a free finder.
// ----------------------------------------------------------------------------
module teq_slots import teq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_slot,
    output logic [31:0]       o_rd_id,
    output logic [31:0]       o_rd_due,
    output logic [15:0]       o_rd_period,
    output logic [1:0]        o_rd_mode,
    output logic              o_free_any,
    output logic [SLOT_W-1:0] o_free_slot
);
    logic [31:0] r_id     [DEPTH];
    logic [31:0] r_due    [DEPTH];
    logic [15:0] r_period [DEPTH];
    logic [1:0]  r_mode   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_idp) begin
            r_id[i_wr.slot]     <= i_wr.id;
            r_period[i_wr.slot] <= i_wr.period;
        end
        if (i_wr.wr_due) begin
            r_due[i_wr.slot] <= i_wr.due;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_mode[i] <= MODE_FREE;
            end
        end else if (i_wr.wr_mode) begin
            r_mode[i_wr.slot] <= i_wr.mode;
        end
    end

    assign o_rd_id     = r_id[i_rd_slot];
    assign o_rd_due    = r_due[i_rd_slot];
    assign o_rd_period = r_period[i_rd_slot];
    assign o_rd_mode   = r_mode[i_rd_slot];

    // lowest free slot; an unused mode code counts as free
    always_comb begin
        o_free_any  = 1'b0;
        o_free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_mode[i] != MODE_QUEUED && r_mode[i] != MODE_WAITING) begin
                o_free_any  = 1'b1;
                o_free_slot = SLOT_W'(i);
            end
        end
    end

endmodule

### hdl/teq_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_order
// Due-ordered list of queued slot numbers, insert and remove by shifting.
// ----------------------------------------------------------------------------
module teq_order import teq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ord_cmd          i_cmd,
    input  logic [CNT_W-1:0]  i_rd_pos,
    output logic [SLOT_W-1:0] o_rd_slot,
    output logic [CNT_W-1:0]  o_count
);
    logic [SLOT_W-1:0] r_list [DEPTH];
    logic [SLOT_W-1:0] n_list [DEPTH];
    logic [CNT_W-1:0]  r_count;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_list[i] = r_list[i];
            if (i_cmd.ins) begin
                if (CNT_W'(i) == i_cmd.pos) begin
                    n_list[i] = i_cmd.slot;
                end else if (CNT_W'(i) > i_cmd.pos && i > 0) begin
                    n_list[i] = r_list[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.rem) begin
                if (CNT_W'(i) >= i_cmd.pos && i < DEPTH - 1) begin
                    n_list[i] = r_list[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.rem) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_rd_slot = r_list[i_rd_pos[SLOT_W-1:0]];
    assign o_count   = r_count;

endmodule

### hdl/teq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue, bound to the top level.
// ----------------------------------------------------------------------------
module teq_checker import teq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_out_status,
    input  logic        i_out_expired,
    input  logic        i_out_last,
    input  logic [15:0] i_out_wait_ms,
    input  logic        i_out_queue_empty
);
    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while previous one in progress");

    // no new request while a non-final response of a burst is still pending
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |-> !i_in_ready)
        else $error("ready while expiry burst unfinished");

    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_expired) |-> (i_out_status == ST_OK))
        else $error("expired response with error status");

    a_empty_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_queue_empty) |-> (i_out_wait_ms == 16'd0))
        else $error("nonzero wait on empty queue");

endmodule

bind timed_event_queue_core teq_checker u_teq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_status      (o_rsp.data.status),
    .i_out_expired     (o_rsp.data.expired),
    .i_out_last        (o_rsp.data.last),
    .i_out_wait_ms     (o_rsp.data.wait_ms),
    .i_out_queue_empty (o_rsp.data.queue_empty)
);
